// ===== rtl/xcfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared constants and types of the XOR-checked frame receiver.
// ----------------------------------------------------------------------------
package xcfr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int Q_DEPTH     = 2;
    localparam int QPTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] SYNC_RESET = 8'd164;

    typedef enum logic [1:0] {
        ST_MSG  = 2'd0,
        ST_CSUM = 2'd1,
        ST_LEN  = 2'd2
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [7:0] id;
        logic [7:0] length;
    } t_job;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

endpackage

`default_nettype wire

// ===== rtl/xcfr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfr_front
// Frame parser: hunts for sync, checks length and checksum, stores payload
// bytes and posts one job per finished frame or error.
// ----------------------------------------------------------------------------
module xcfr_front import xcfr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cfg_valid,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic    i_q_full,
    input  wire logic    i_back_busy,
    output logic         o_push,
    output t_job         o_push_job,
    output t_mem_wr      o_mem_wr
);

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_ID   = 4'b0100,
        PH_BODY = 4'b1000
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_sync;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_id, n_id;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_xor, n_xor;
    logic             accept;
    logic             body_data;

    assign body_data  = (r_phase == PH_BODY) && (8'(r_count) < r_len);
    assign o_in_ready = !i_q_full && !(body_data && i_back_busy);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_id       = r_id;
        n_count    = r_count;
        n_xor      = r_xor;
        o_push     = 1'b0;
        o_push_job = '{status: ST_MSG, id: r_id, length: r_len};
        o_mem_wr   = '{en: 1'b0, addr: ADDR_W'(r_count), data: i_rx_byte};
        if (accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == r_sync) begin
                        n_xor   = i_rx_byte;
                        n_count = '0;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (i_rx_byte > 8'(MAX_PAYLOAD)) begin
                        o_push     = 1'b1;
                        o_push_job = '{status: ST_LEN, id: 8'd0, length: i_rx_byte};
                        n_phase    = PH_HUNT;
                        n_len      = '0;
                        n_id       = '0;
                        n_count    = '0;
                        n_xor      = '0;
                    end else begin
                        n_len   = i_rx_byte;
                        n_xor   = r_xor ^ i_rx_byte;
                        n_phase = PH_ID;
                    end
                end
                PH_ID: begin
                    n_id    = i_rx_byte;
                    n_xor   = r_xor ^ i_rx_byte;
                    n_count = '0;
                    n_phase = PH_BODY;
                end
                PH_BODY: begin
                    if (body_data) begin
                        o_mem_wr.en = 1'b1;
                        n_xor       = r_xor ^ i_rx_byte;
                        n_count     = r_count + 1'b1;
                    end else begin
                        o_push = 1'b1;
                        if (i_rx_byte != r_xor) begin
                            o_push_job.status = ST_CSUM;
                        end
                        n_phase = PH_HUNT;
                        n_len   = '0;
                        n_id    = '0;
                        n_count = '0;
                        n_xor   = '0;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_sync  <= SYNC_RESET;
            r_len   <= '0;
            r_id    <= '0;
            r_count <= '0;
            r_xor   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_id    <= n_id;
            r_count <= n_count;
            r_xor   <= n_xor;
            if (i_cfg_valid) begin
                r_sync <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/xcfr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfr_queue
// Short job queue between the parser and the replay engine.
// ----------------------------------------------------------------------------
module xcfr_queue import xcfr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_push_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_pop_job,
    output logic      o_empty
);

    t_job              r_slot [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full    = (r_count == QCNT_W'(Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_job = r_slot[r_rd_ptr];
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/xcfr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfr_back
// Replay engine: holds the payload buffer and turns each job into a run of
// result beats.
// ----------------------------------------------------------------------------
module xcfr_back import xcfr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_mem_wr    i_mem_wr,
    input  wire logic  i_q_empty,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_busy,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output logic [1:0] o_status,
    output logic [7:0] o_message_id,
    output logic [7:0] o_message_length,
    output logic [4:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic       o_last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_LOAD = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    logic [7:0]       mem [MAX_PAYLOAD];
    logic [7:0]       r_rd_data;
    t_state           r_state;
    t_job             r_job;
    logic [CNT_W-1:0] r_idx;
    logic             r_out_valid;
    t_status          r_status;
    logic [7:0]       r_id;
    logic [7:0]       r_length;
    logic [4:0]       r_index;
    logic [7:0]       r_payload;
    logic             r_last;
    logic             single;

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
        r_rd_data <= mem[ADDR_W'(r_idx)];
    end

    assign single = (r_job.status != ST_MSG) || (r_job.length == 8'd0);
    assign o_pop  = (r_state == S_IDLE) && !i_q_empty;
    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_job   <= i_job;
                        r_idx   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_out_valid <= 1'b1;
                    r_status    <= r_job.status;
                    r_id        <= r_job.id;
                    r_length    <= r_job.length;
                    r_index     <= 5'(r_idx);
                    r_payload   <= single ? 8'd0 : r_rd_data;
                    r_last      <= single || ((8'(r_idx) + 8'd1) == r_job.length);
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_message_id     = r_id;
    assign o_message_length = r_length;
    assign o_byte_index     = r_index;
    assign o_payload_byte   = r_payload;
    assign o_last           = r_last;

endmodule

`default_nettype wire

// ===== rtl/xor_checked_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver
// Sync, length, id, payload and XOR checksum deframer with buffered replay.
//
// Channel   Handshake                  Payload
// cfg       i_cfg_valid / o_cfg_ready  i_cfg_data (sync byte)
// in        i_in_valid / o_in_ready    i_rx_byte
// out       o_out_valid / i_out_ready  o_status, o_message_id, o_message_length,
//                                      o_byte_index, o_payload_byte, o_last
//
// The parser takes one byte beat per cycle while the job queue is not full.
// A payload byte waits while an earlier job is queued or being replayed,
// since both share the buffer. Replay picks a job, then for each result beat
// does a buffer read, output load and output beat; the buffer read is registered.
// Reset sets the sync byte to 164 and the parser to hunting; no clearing pass.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver import xcfr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_status,
    output logic [7:0]      o_message_id,
    output logic [7:0]      o_message_length,
    output logic [4:0]      o_byte_index,
    output logic [7:0]      o_payload_byte,
    output logic            o_last
);

    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    t_job    push_job;
    t_job    pop_job;
    t_mem_wr mem_wr;
    logic    back_active;
    logic    back_busy;

    assign o_cfg_ready = 1'b1;
    assign back_busy   = back_active || !q_empty;

    xcfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (q_full),
        .i_back_busy (back_busy),
        .o_push      (push),
        .o_push_job  (push_job),
        .o_mem_wr    (mem_wr)
    );

    xcfr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_pop_job  (pop_job),
        .o_empty    (q_empty)
    );

    xcfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mem_wr         (mem_wr),
        .i_q_empty        (q_empty),
        .i_job            (pop_job),
        .o_pop            (pop),
        .o_busy           (back_active),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_message_id     (o_message_id),
        .o_message_length (o_message_length),
        .o_byte_index     (o_byte_index),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the XOR-checked frame receiver. Serial bytes are
// streamed in as frames (good, bad checksum, oversize length, cut short) and
// as line noise under four sync byte settings. A scoreboard follows the parser
// byte by byte and compares every output beat with the expected message run.
// ----------------------------------------------------------------------------
module tb_top;
    import xcfr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned LONG_HOLD     = 300;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LENGTH = 2'd1,
        PH_ID     = 2'd2,
        PH_BODY   = 2'd3
    } t_rx_phase;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_CUT
    } t_frame_kind;

    typedef struct packed {
        t_status    status;
        logic [7:0] id;
        logic [7:0] length;
        logic [4:0] index;
        logic [7:0] data;
        logic       last;
    } t_beat;

    typedef logic [7:0] t_byte_q[$];

    class frame_scoreboard;
        logic [7:0]  sync_byte;
        t_rx_phase   phase;
        logic [7:0]  frame_len;
        logic [7:0]  frame_id;
        logic [7:0]  xor_sum;
        logic [5:0]  taken;
        logic [7:0]  payload_buf [MAX_PAYLOAD];
        t_beat       pending_beats[$];
        int unsigned mismatches;

        function new();
            sync_byte  = SYNC_RESET;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            phase     = PH_HUNT;
            frame_len = '0;
            frame_id  = '0;
            taken     = '0;
            xor_sum   = '0;
        endfunction

        function void set_sync(logic [7:0] value);
            sync_byte = value;
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction

        function void queue_beat(t_status st, logic [7:0] id, logic [7:0] len,
                                 logic [4:0] idx, logic [7:0] data, logic last);
            t_beat beat;
            beat.status = st;
            beat.id     = id;
            beat.length = len;
            beat.index  = idx;
            beat.data   = data;
            beat.last   = last;
            pending_beats.push_back(beat);
        endfunction

        function void take_byte(logic [7:0] b);
            case (phase)
                PH_HUNT: begin
                    if (b == sync_byte) begin
                        xor_sum = b;
                        taken   = '0;
                        phase   = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (int'(b) > MAX_PAYLOAD) begin
                        queue_beat(ST_LEN, 8'h00, b, 5'd0, 8'h00, 1'b1);
                        restart();
                    end else begin
                        frame_len = b;
                        xor_sum   = xor_sum ^ b;
                        phase     = PH_ID;
                    end
                end
                PH_ID: begin
                    frame_id = b;
                    xor_sum  = xor_sum ^ b;
                    taken    = '0;
                    phase    = PH_BODY;
                end
                default: begin
                    if (taken < frame_len && int'(taken) < MAX_PAYLOAD) begin
                        payload_buf[taken] = b;
                        xor_sum            = xor_sum ^ b;
                        taken              = taken + 6'd1;
                    end else if (b != xor_sum) begin
                        queue_beat(ST_CSUM, frame_id, frame_len, 5'd0, 8'h00, 1'b1);
                        restart();
                    end else if (frame_len == 8'd0) begin
                        queue_beat(ST_MSG, frame_id, 8'h00, 5'd0, 8'h00, 1'b1);
                        restart();
                    end else begin
                        for (int k = 0; k < int'(frame_len); k++) begin
                            queue_beat(ST_MSG, frame_id, frame_len, 5'(k), payload_buf[k],
                                       k + 1 == int'(frame_len));
                        end
                        restart();
                    end
                end
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t ns  mismatch: %s", $time, what);
        endtask

        task check_beat(logic [1:0] st, logic [7:0] id, logic [7:0] len,
                        logic [4:0] idx, logic [7:0] data, logic last);
            t_beat want;
            if (pending_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat status %0d id %0h idx %0d",
                                          st, id, idx));
            end else begin
                want = pending_beats.pop_front();
                if (st != want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
                if (id != want.id)
                    report_mismatch($sformatf("message_id %0h, expected %0h", id, want.id));
                if (len != want.length)
                    report_mismatch($sformatf("message_length %0d, expected %0d",
                                              len, want.length));
                if (idx != want.index)
                    report_mismatch($sformatf("byte_index %0d, expected %0d", idx, want.index));
                if (data != want.data)
                    report_mismatch($sformatf("payload_byte %0h, expected %0h at index %0d",
                                              data, want.data, want.index));
                if (last != want.last)
                    report_mismatch($sformatf("last %0b, expected %0b at index %0d",
                                              last, want.last, want.index));
            end
        endtask

        task check_drained();
            if (pending_beats.size() != 0)
                report_mismatch($sformatf("%0d expected beats never arrived",
                                          pending_beats.size()));
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data = 8'h00;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_cfg_ready;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_status;
    logic [7:0] o_message_id;
    logic [7:0] o_message_length;
    logic [4:0] o_byte_index;
    logic [7:0] o_payload_byte;
    logic       o_last;

    frame_scoreboard sb;
    bit              quiet = 1'b0;
    int unsigned     holds_asked = 0;
    int unsigned     holds_done = 0;
    int unsigned     bytes_sent = 0;

    xor_checked_frame_receiver dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_message_id     (o_message_id),
        .o_message_length (o_message_length),
        .o_byte_index     (o_byte_index),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // The receiver normally drops ready at random, but on request it holds off
    // for a long stretch so that the block backs up and stalls its input.
    initial begin : sink
        int unsigned held;
        forever begin
            @(posedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                i_out_ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 99) < 11) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_beat(o_status, o_message_id, o_message_length, o_byte_index,
                          o_payload_byte, o_last);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(0, 99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_byte_q body, input logic [7:0] id,
                              input t_frame_kind kind);
        logic [7:0] sum;
        int         n;
        sum = sb.sync_byte ^ 8'(body.size()) ^ id;
        n   = (kind == FRAME_CUT) ? body.size() / 2 : body.size();
        send_byte(sb.sync_byte);
        send_byte(8'(body.size()));
        send_byte(id);
        for (int k = 0; k < n; k++) begin
            send_byte(body[k]);
            sum = sum ^ body[k];
        end
        if (kind == FRAME_GOOD) begin
            send_byte(sum);
        end else if (kind == FRAME_BAD_SUM) begin
            send_byte(sum ^ 8'($urandom_range(1, 255)));
        end
    endtask

    task automatic random_traffic(input int unsigned budget);
        int unsigned stop_at;
        int          pick;
        int          roll;
        int          len;
        t_byte_q     body;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            roll = $urandom_range(0, 99);
            if (roll < 10) len = 0;
            else if (roll < 20) len = MAX_PAYLOAD;
            else if (roll < 30) len = $urandom_range(9, MAX_PAYLOAD - 1);
            else len = $urandom_range(1, 8);
            body = {};
            repeat (len) body.push_back(8'($urandom_range(0, 255)));
            if (pick < 8) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 14) begin
                send_byte(sb.sync_byte);
                send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            end else if (pick < 18) begin
                send_frame(body, 8'($urandom_range(0, 255)), FRAME_CUT);
            end else if (pick < 30) begin
                send_frame(body, 8'($urandom_range(0, 255)), FRAME_BAD_SUM);
            end else begin
                send_frame(body, 8'($urandom_range(0, 255)), FRAME_GOOD);
            end
        end
    endtask

    // Completes any frame still open, then lets the block drain and go idle.
    task automatic settle();
        int unsigned waited;
        while (sb.phase != PH_HUNT) send_byte(8'($urandom_range(0, 255)));
        i_in_valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sync(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_sync(value);
    endtask

    initial begin : stimulus
        t_byte_q body;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(8'h00);
        send_byte(8'hFF);
        body = {};
        send_frame(body, 8'h00, FRAME_GOOD);
        send_byte(sb.sync_byte);
        send_byte(8'(MAX_PAYLOAD + 1));
        send_byte(sb.sync_byte);
        send_byte(8'hFF);
        body = {8'h7E};
        send_frame(body, 8'hC3, FRAME_BAD_SUM);
        body = {8'hFF, 8'h00};
        send_frame(body, 8'hFF, FRAME_GOOD);
        settle();

        write_sync(8'h00);
        random_traffic(70);
        settle();

        write_sync(8'hFF);
        quiet = 1'b1;
        random_traffic(70);
        settle();
        quiet = 1'b0;

        write_sync(8'($urandom_range(1, 254)));
        holds_asked++;
        random_traffic(75);
        settle();

        sb.check_drained();
        if (sb.mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
